@@ src/assert_macros.svh @@
// assertion macros shared by the dns answer record filter modules
// no dependencies; included by each module that carries checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ src/dnsarf_pkg.sv @@
// shared types and constants for the dns answer record filter
// no dependencies; used by every module of the block
package dnsarf_pkg;

	// default largest message size in bytes
	localparam int MAX_MESSAGE_DEF = 4096;

	// result queue geometry
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// result kinds
	localparam logic [1:0] KIND_MATCH = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// configuration register indexes
	localparam logic CFG_WANTED_CLASS = 1'b0;
	localparam logic CFG_WANTED_TYPE = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [11:0] rdata_offset;
		logic [15:0] rdata_length;
		logic [15:0] match_count;
		logic last_result;
	} out_item_t;

	// up to two results pushed per byte, first slot filled first
	typedef struct packed {
		logic first_valid;
		logic second_valid;
		out_item_t first;
		out_item_t second;
	} push_t;

endpackage

@@ src/dnsarf_front.sv @@
// front end: accepts message bytes, walks the dns message and emits results
// depends on dnsarf_pkg and assert_macros.svh
`include "assert_macros.svh"

module dnsarf_front #(
	parameter int MAX_MESSAGE = dnsarf_pkg::MAX_MESSAGE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	input logic hold,
	input dnsarf_pkg::in_item_t in_data,
	output dnsarf_pkg::push_t push
);

	localparam int POS_W = $clog2(MAX_MESSAGE + 2);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE);
	localparam logic [POS_W-1:0] POS_OVER = POS_W'(MAX_MESSAGE + 1);
	localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(11);
	localparam logic [15:0] QFIXED_BYTES = 16'd4;
	localparam logic [15:0] AFIXED_BYTES = 16'd10;
	localparam logic [7:0] POINTER_MARK = 8'hc0;

	// parse phases
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_NAME = 3'd1;
	localparam logic [2:0] PH_LABEL = 3'd2;
	localparam logic [2:0] PH_POINTER = 3'd3;
	localparam logic [2:0] PH_QFIXED = 3'd4;
	localparam logic [2:0] PH_AFIXED = 3'd5;
	localparam logic [2:0] PH_RDATA = 3'd6;
	localparam logic [2:0] PH_DONE = 3'd7;

	logic [POS_W-1:0] pos_q, pos_d, pos_inc;
	logic [2:0] phase_q, phase_d;
	logic [15:0] qleft_q, qleft_d;
	logic [15:0] aleft_q, aleft_d, aleft_dec;
	logic [15:0] skip_q, skip_d, skip_dec;
	logic [15:0] matches_q, matches_d;
	logic [71:0] shift_q, shift_d;
	logic [79:0] window;
	logic [15:0] wanted_class_q, wanted_type_q;
	logic accept, match_hit, clean;
	logic [15:0] rec_type, rec_class, rec_size;
	dnsarf_pkg::out_item_t match_item, end_item;

	assign accept = in_valid && !hold;
	assign window = {shift_q, in_data.data_byte};
	assign rec_type = window[79:64];
	assign rec_class = window[63:48];
	assign rec_size = window[15:0];
	assign pos_inc = pos_q + POS_W'(1);
	assign skip_dec = (skip_q != 16'd0) ? skip_q - 16'd1 : skip_q;
	assign aleft_dec = (aleft_q != 16'd0) ? aleft_q - 16'd1 : aleft_q;

	// next parser state for one byte
	always_comb begin
		pos_d = pos_q;
		phase_d = phase_q;
		qleft_d = qleft_q;
		aleft_d = aleft_q;
		skip_d = skip_q;
		matches_d = matches_q;
		shift_d = shift_q;
		match_hit = 1'b0;
		if (pos_q >= POS_MAX) begin
			pos_d = POS_OVER;
		end else begin
			pos_d = pos_inc;
			shift_d = window[71:0];
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q == POS_HDR_LAST) begin
						qleft_d = window[63:48];
						aleft_d = window[47:32];
						if (window[63:48] == 16'd0 && window[47:32] == 16'd0)
							phase_d = PH_DONE;
						else
							phase_d = PH_NAME;
					end
				end
				PH_NAME: begin
					if (in_data.data_byte == 8'd0) begin
						phase_d = (qleft_q != 16'd0) ? PH_QFIXED : PH_AFIXED;
						skip_d = (qleft_q != 16'd0) ? QFIXED_BYTES : AFIXED_BYTES;
					end else if ((in_data.data_byte & POINTER_MARK) == POINTER_MARK) begin
						phase_d = PH_POINTER;
					end else begin
						skip_d = {8'd0, in_data.data_byte};
						phase_d = PH_LABEL;
					end
				end
				PH_LABEL: begin
					skip_d = skip_dec;
					if (skip_dec == 16'd0)
						phase_d = PH_NAME;
				end
				PH_POINTER: begin
					phase_d = (qleft_q != 16'd0) ? PH_QFIXED : PH_AFIXED;
					skip_d = (qleft_q != 16'd0) ? QFIXED_BYTES : AFIXED_BYTES;
				end
				PH_QFIXED: begin
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						qleft_d = qleft_q - 16'd1;
						if (qleft_q == 16'd1 && aleft_q == 16'd0)
							phase_d = PH_DONE;
						else
							phase_d = PH_NAME;
					end
				end
				PH_AFIXED: begin
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						if (rec_class == wanted_class_q && rec_type == wanted_type_q) begin
							match_hit = 1'b1;
							if (matches_q != 16'hffff)
								matches_d = matches_q + 16'd1;
						end
						if (rec_size == 16'd0) begin
							aleft_d = aleft_dec;
							phase_d = (aleft_dec == 16'd0) ? PH_DONE : PH_NAME;
						end else begin
							skip_d = rec_size;
							phase_d = PH_RDATA;
						end
					end
				end
				PH_RDATA: begin
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						aleft_d = aleft_dec;
						phase_d = (aleft_dec == 16'd0) ? PH_DONE : PH_NAME;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign clean = (pos_q < POS_MAX) && (phase_d == PH_DONE);

	// result items for this byte
	always_comb begin
		match_item.kind = dnsarf_pkg::KIND_MATCH;
		match_item.rdata_offset = 12'(pos_inc);
		match_item.rdata_length = rec_size;
		match_item.match_count = matches_d;
		match_item.last_result = 1'b0;
		end_item.kind = clean ? dnsarf_pkg::KIND_END : dnsarf_pkg::KIND_ERROR;
		end_item.rdata_offset = 12'd0;
		end_item.rdata_length = 16'd0;
		end_item.match_count = matches_d;
		end_item.last_result = 1'b1;
		push.first_valid = accept && (match_hit || in_data.last_byte);
		push.second_valid = accept && match_hit && in_data.last_byte;
		push.first = match_hit ? match_item : end_item;
		push.second = end_item;
	end

	// parser state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= PH_HEADER;
			qleft_q <= '0;
			aleft_q <= '0;
			skip_q <= '0;
			matches_q <= '0;
			wanted_class_q <= 16'd1;
			wanted_type_q <= 16'd1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dnsarf_pkg::CFG_WANTED_CLASS: wanted_class_q <= cfg_data;
					dnsarf_pkg::CFG_WANTED_TYPE: wanted_type_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (in_data.last_byte) begin
					pos_q <= '0;
					phase_q <= PH_HEADER;
					qleft_q <= '0;
					aleft_q <= '0;
					skip_q <= '0;
					matches_q <= '0;
				end else begin
					pos_q <= pos_d;
					phase_q <= phase_d;
					qleft_q <= qleft_d;
					aleft_q <= aleft_d;
					skip_q <= skip_d;
					matches_q <= matches_d;
				end
			end
		end
	end

	// byte history for header counts and the answer fixed part
	always_ff @(posedge clk) begin
		if (accept)
			shift_q <= shift_d;
	end

	`ASSERT_NEXT(a_clear_after_last, clk, arst_n, accept && in_data.last_byte, pos_q == '0 && phase_q == PH_HEADER && matches_q == '0)
	`ASSERT_SAME(a_pos_bounded, clk, arst_n, 1'b1, pos_q <= POS_OVER)
	`ASSERT_SAME(a_second_is_end, clk, arst_n, push.second_valid, push.first_valid && push.first.kind == dnsarf_pkg::KIND_MATCH && push.second.last_result)

endmodule

@@ src/dnsarf_queue.sv @@
// short result queue between the parser and the output stage
// depends on dnsarf_pkg and assert_macros.svh
`include "assert_macros.svh"

module dnsarf_queue (
	input logic clk,
	input logic arst_n,
	input dnsarf_pkg::push_t push,
	input logic pop,
	output dnsarf_pkg::out_item_t head,
	output logic nonempty,
	output logic nearly_full
);

	localparam int DEPTH = dnsarf_pkg::QUEUE_DEPTH;
	localparam int PTR_W = dnsarf_pkg::QPTR_W;
	localparam int CNT_W = dnsarf_pkg::QCNT_W;

	dnsarf_pkg::out_item_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q, push_n;
	logic do_pop;

	assign push_n = CNT_W'(push.first_valid) + CNT_W'(push.second_valid);
	assign do_pop = pop && nonempty;
	assign nonempty = count_q != '0;
	assign nearly_full = count_q > CNT_W'(DEPTH - 2);
	assign head = mem[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push.first_valid)
			mem[wr_ptr_q] <= push.first;
		if (push.second_valid)
			mem[wr_ptr_q + PTR_W'(1)] <= push.second;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + push_n - CNT_W'(do_pop);
		end
	end

	`ASSERT_SAME(a_push_has_room, clk, arst_n, push.first_valid, count_q <= CNT_W'(DEPTH - 2))
	`ASSERT_SAME(a_pop_not_empty, clk, arst_n, pop, nonempty)

endmodule

@@ src/dnsarf_back.sv @@
// back end: output register that transfers queued results downstream
// depends on dnsarf_pkg
module dnsarf_back (
	input logic clk,
	input logic arst_n,
	input logic q_nonempty,
	input dnsarf_pkg::out_item_t q_head,
	output logic q_pop,
	output logic out_valid,
	input logic out_stall,
	output dnsarf_pkg::out_item_t out_data
);

	logic out_valid_q;
	dnsarf_pkg::out_item_t out_q;

	// load when the register is empty or its transfer completes
	assign q_pop = q_nonempty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			out_q <= q_head;
	end

endmodule

@@ src/dns_answer_record_filter.sv @@
// One message byte is taken per cycle, back to back, while in_stall is low; the parser
// updates in the same cycle. A result is offered after a queue write, then the output
// register; a byte may cause two results, which leave one per cycle unless out_stall
// is high. Input stalls only while the four-entry queue holds more than two results.
// Asynchronous active-low reset returns the parser to the header and sets both wanted
// class and type to 1; no clearing pass is needed.
module dns_answer_record_filter #(
	parameter int MAX_MESSAGE = dnsarf_pkg::MAX_MESSAGE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input dnsarf_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output dnsarf_pkg::out_item_t out_data
);

	dnsarf_pkg::push_t push;
	dnsarf_pkg::out_item_t q_head;
	logic q_nonempty, q_pop, q_nearly_full;

	assign in_stall = q_nearly_full;

	// parser
	dnsarf_front #(
		.MAX_MESSAGE(MAX_MESSAGE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.hold(q_nearly_full),
		.in_data(in_data),
		.push(push)
	);

	// result queue
	dnsarf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(q_pop),
		.head(q_head),
		.nonempty(q_nonempty),
		.nearly_full(q_nearly_full)
	);

	// output stage
	dnsarf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_nonempty(q_nonempty),
		.q_head(q_head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
